// ----- rtl/core/lmlt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode/line timing package
// Mode codes, dot and line limits and the shared state/result/config types.
// ----------------------------------------------------------------------------
package lmlt_pkg;

  // display modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_WINDOW_ENABLE  = 3'd0;
  localparam logic [2:0] REG_LY_COMPARE     = 3'd1;
  localparam logic [2:0] REG_LYC_IRQ_ENABLE = 3'd2;
  localparam logic [2:0] REG_WINDOW_Y       = 3'd3;
  localparam logic [2:0] REG_WIN_LEFT       = 3'd4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  // dot and line limits
  localparam logic [8:0] DOTS_OAM      = 9'd80;
  localparam logic [8:0] DOTS_DRAW     = 9'd172;
  localparam logic [8:0] DOTS_HBLANK   = 9'd204;
  localparam logic [8:0] DOTS_LINE     = 9'd456;
  localparam logic [7:0] LINE_LAST     = 8'd153;  // lines total minus one
  localparam logic [7:0] LINES_VISIBLE = 8'd144;
  localparam logic [7:0] WX_LIMIT      = 8'd166;

  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] dot;
    logic [7:0] line;
    logic [7:0] win;
    logic       match;
    logic       blank_done;
  } timing_t;

  typedef struct packed {
    logic       window_enable;
    logic [7:0] ly_compare;
    logic       lyc_irq_enable;
    logic [7:0] window_y;
    logic [7:0] win_left;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line;
    logic [7:0] window_line;
    logic       coincidence;
    logic       vblank_irq;
    logic       lyc_irq;
    logic       frame_swap;
    logic       sprite_eval_start;
    logic       line_render_start;
  } result_t;

endpackage

// ----- rtl/core/lmlt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode/line timing channels
// Valid/ready interfaces for the dot tick input and the timing result.
// ----------------------------------------------------------------------------
interface lmlt_in_if;
  logic valid;
  logic ready;
  logic lcd_on;

  modport source (output valid, output lcd_on, input ready);
  modport sink   (input valid, input lcd_on, output ready);
endinterface

interface lmlt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] line;
  logic [7:0] window_line;
  logic       coincidence;
  logic       vblank_irq;
  logic       lyc_irq;
  logic       frame_swap;
  logic       sprite_eval_start;
  logic       line_render_start;

  modport source (
    output valid, output mode, output line, output window_line, output coincidence,
    output vblank_irq, output lyc_irq, output frame_swap, output sprite_eval_start,
    output line_render_start, input ready
  );
  modport sink (
    input valid, input mode, input line, input window_line, input coincidence,
    input vblank_irq, input lyc_irq, input frame_swap, input sprite_eval_start,
    input line_render_start, output ready
  );
endinterface

// ----- rtl/core/lmlt_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode/line timing step
// Next timing state and result for one dot tick.
// ----------------------------------------------------------------------------
module lmlt_step (
  input  lmlt_pkg::timing_t st,
  input  lmlt_pkg::cfg_t    cfg,
  input  logic              lcd_on,
  output lmlt_pkg::timing_t st_nxt,
  output lmlt_pkg::result_t res
);

  logic [8:0] dot_inc;
  logic [7:0] line_inc;
  logic       line_hit;
  logic       vblank_p;
  logic       lyc_p;
  logic       swap_p;
  logic       spr_p;
  logic       rend_p;

  assign dot_inc  = st.dot + 9'd1;
  // line wraps modulo the line total
  assign line_inc = (st.line >= lmlt_pkg::LINE_LAST) ? 8'd0 : st.line + 8'd1;
  assign line_hit = (line_inc == cfg.ly_compare);

  always_comb begin
    st_nxt   = st;
    vblank_p = 1'b0;
    lyc_p    = 1'b0;
    swap_p   = 1'b0;
    spr_p    = 1'b0;
    rend_p   = 1'b0;
    if (!lcd_on) begin
      st_nxt.dot  = 9'd0;
      st_nxt.line = 8'd0;
      st_nxt.win  = 8'd0;
      st_nxt.mode = lmlt_pkg::MODE_HBLANK;
      if (!st.blank_done) begin
        swap_p            = 1'b1;
        st_nxt.blank_done = 1'b1;
      end
    end else begin
      st_nxt.dot        = dot_inc;
      st_nxt.blank_done = 1'b0;
      case (st.mode)
        lmlt_pkg::MODE_HBLANK: begin
          if (dot_inc >= lmlt_pkg::DOTS_HBLANK) begin
            st_nxt.dot   = 9'd0;
            st_nxt.line  = line_inc;
            st_nxt.match = line_hit;
            lyc_p        = line_hit & cfg.lyc_irq_enable;
            if (line_inc == lmlt_pkg::LINES_VISIBLE) begin
              st_nxt.win  = 8'd0;
              st_nxt.mode = lmlt_pkg::MODE_VBLANK;
              swap_p      = 1'b1;
              vblank_p    = 1'b1;
            end else begin
              st_nxt.mode = lmlt_pkg::MODE_OAM;
              if (cfg.window_enable && (line_inc > cfg.window_y) &&
                  (cfg.win_left <= lmlt_pkg::WX_LIMIT)) begin
                st_nxt.win = st.win + 8'd1;
              end
            end
          end
        end
        lmlt_pkg::MODE_VBLANK: begin
          if (dot_inc >= lmlt_pkg::DOTS_LINE) begin
            st_nxt.dot   = 9'd0;
            st_nxt.line  = line_inc;
            st_nxt.match = line_hit;
            lyc_p        = line_hit & cfg.lyc_irq_enable;
            // last line is compared, then wraps at once
            if (line_inc >= lmlt_pkg::LINE_LAST) begin
              st_nxt.line = 8'd0;
              st_nxt.mode = lmlt_pkg::MODE_OAM;
            end
          end
        end
        lmlt_pkg::MODE_OAM: begin
          if (dot_inc >= lmlt_pkg::DOTS_OAM) begin
            st_nxt.dot  = 9'd0;
            st_nxt.mode = lmlt_pkg::MODE_DRAW;
            spr_p       = 1'b1;
          end
        end
        default: begin
          if (dot_inc >= lmlt_pkg::DOTS_DRAW) begin
            st_nxt.dot  = 9'd0;
            st_nxt.mode = lmlt_pkg::MODE_HBLANK;
            rend_p      = 1'b1;
          end
        end
      endcase
    end
  end

  assign res.mode              = st_nxt.mode;
  assign res.line              = st_nxt.line;
  assign res.window_line       = st_nxt.win;
  assign res.coincidence       = st_nxt.match;
  assign res.vblank_irq        = vblank_p;
  assign res.lyc_irq           = lyc_p;
  assign res.frame_swap        = swap_p;
  assign res.sprite_eval_start = spr_p;
  assign res.line_render_start = rend_p;

endmodule

// ----- rtl/core/lcd_mode_line_timing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode and line timing generator
// Dot-clock sequencer: mode, line, window line, coincidence and event pulses.
// ----------------------------------------------------------------------------
// Each input item is one dot tick carrying lcd_on; each tick yields exactly one
// result item holding mode, line, window line and coincidence after the tick,
// plus the event pulses (vblank, lyc interrupt, frame swap, sprite eval start,
// line render start). Visible lines 0-143 run 80 dots OAM scan, 172 dots
// drawing and 204 dots HBLANK; VBLANK lines run 456 dots, and reaching line 153
// wraps to line 0 in the same tick. With lcd_on low the timing is held cleared
// in HBLANK and a single frame_swap pulse presents a blank frame. Throughput is
// one item per clock while in_ch.ready is high: the next state comes from one
// short combinational step between the timing state register and the result
// register, so the counters advance on every accepted tick. A result register
// plus one skid entry decouple the sides; in_ch.ready drops only when both
// hold results not yet taken. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block itself
// does not enforce this. Indexes beyond 4 are ignored.
// ----------------------------------------------------------------------------
module lcd_mode_line_timing (
  input  logic                                 clk,
  input  logic                                 rst_n,
  lmlt_in_if.sink                              in_ch,
  lmlt_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [lmlt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lmlt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // timing state and configuration
  lmlt_pkg::timing_t st_r;
  lmlt_pkg::timing_t st_nxt;
  lmlt_pkg::cfg_t    cfg_r;
  lmlt_pkg::result_t res;

  // result register and skid entry
  lmlt_pkg::result_t out_data_r;
  lmlt_pkg::result_t skid_data_r;
  logic              out_valid_r;
  logic              skid_valid_r;
  logic              out_valid_nxt;
  logic              skid_valid_nxt;

  logic in_acc;
  logic out_free;
  logic load_out_new;
  logic load_out_skid;
  logic load_skid;

  lmlt_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .lcd_on (in_ch.lcd_on),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && !skid_valid_r;
  // output slot empties this cycle
  assign out_free    = !out_valid_r || out_ch.ready;

  // skid drains first so item order holds
  assign load_out_skid = out_free && skid_valid_r;
  assign load_out_new  = out_free && !skid_valid_r && in_acc;
  assign load_skid     = in_acc && !load_out_new;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      out_valid_nxt  = skid_valid_r || in_acc;
      skid_valid_nxt = skid_valid_r && in_acc;
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
    end
  end

  // timing state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode       <= lmlt_pkg::MODE_OAM;
      st_r.dot        <= 9'd0;
      st_r.line       <= 8'd0;
      st_r.win        <= 8'd0;
      st_r.match      <= 1'b0;
      st_r.blank_done <= 1'b0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmlt_pkg::REG_WINDOW_ENABLE:  cfg_r.window_enable  <= cfg_data[0];
        lmlt_pkg::REG_LY_COMPARE:     cfg_r.ly_compare     <= cfg_data;
        lmlt_pkg::REG_LYC_IRQ_ENABLE: cfg_r.lyc_irq_enable <= cfg_data[0];
        lmlt_pkg::REG_WINDOW_Y:       cfg_r.window_y       <= cfg_data;
        lmlt_pkg::REG_WIN_LEFT:       cfg_r.win_left       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_skid) begin
      out_data_r <= skid_data_r;
    end else if (load_out_new) begin
      out_data_r <= res;
    end
    if (load_skid) begin
      skid_data_r <= res;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.mode              = out_data_r.mode;
  assign out_ch.line              = out_data_r.line;
  assign out_ch.window_line       = out_data_r.window_line;
  assign out_ch.coincidence       = out_data_r.coincidence;
  assign out_ch.vblank_irq        = out_data_r.vblank_irq;
  assign out_ch.lyc_irq           = out_data_r.lyc_irq;
  assign out_ch.frame_swap        = out_data_r.frame_swap;
  assign out_ch.sprite_eval_start = out_data_r.sprite_eval_start;
  assign out_ch.line_render_start = out_data_r.line_render_start;

`ifndef SYNTHESIS
  // line 153 is never held: it wraps within the tick
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.line < lmlt_pkg::LINE_LAST)
    else $error("line counter reached wrap value");

  // skid only fills behind a held result
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty result register");

  a_spr_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.sprite_eval_start) |->
      (out_data_r.mode == lmlt_pkg::MODE_DRAW))
    else $error("sprite eval start outside drawing");

  a_vblank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.vblank_irq) |->
      (out_data_r.frame_swap && out_data_r.line == lmlt_pkg::LINES_VISIBLE))
    else $error("vblank pulse without frame swap at first vblank line");
`endif

endmodule

// ----- bench/tb_lcd_mode_line_timing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode/line timing testbench
// Feeds dot ticks through the input channel, predicts mode, line, window line,
// coincidence and event pulses in step with the block and checks every result
// item in order. Covers display on/off, the OAM/draw/HBLANK steps of the first
// lines, line compare, window counting at the left limit, and several register
// settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_lcd_mode_line_timing;

  // timing of the bench itself
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no handshake
  localparam int unsigned CALM_FROM      = 500;   // window with no idling
  localparam int unsigned CALM_TO        = 1200;
  localparam int unsigned TAIL_CYCLES    = 8;     // idle clocks after the last drain
  localparam int unsigned PRINT_CAP      = 50;
  localparam int unsigned REG_COUNT      = 5;
  localparam int unsigned REG_INDEX_MAX  = (1 << lmlt_pkg::CFG_INDEX_W) - 1;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [lmlt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lmlt_pkg::CFG_DATA_W-1:0]  cfg_data;

  lmlt_in_if  in_ch ();
  lmlt_out_if out_ch ();

  lcd_mode_line_timing u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  bit                tick_q[$];    // lcd_on of each dot tick still to be sent
  lmlt_pkg::result_t timing_q[$];  // predicted result items, oldest first
  lmlt_pkg::timing_t tstate;       // predicted timing state of the block
  lmlt_pkg::cfg_t    regs;         // bench copy of the registers
  logic              in_fire;      // set at the edge an item was taken
  int unsigned       cycle_cnt;
  int unsigned       stall_cnt;
  int unsigned       n_err;
  int unsigned       n_ticks, n_checked, n_settings;
  int unsigned       n_lines, n_lyc, n_blank;
  logic              calm;

  assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

  // --------------------------------------------------------------------------
  // Mismatch report: one line per failure, printing capped, all counted
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_err < PRINT_CAP)
      $display("MISMATCH %s: got %0d, want %0d (result %0d, t=%0t)",
               what, got, want, n_checked, $realtime);
    n_err++;
  endtask

  // --------------------------------------------------------------------------
  // Timing predictor
  // --------------------------------------------------------------------------
  // Steps the line counter and redoes the coincidence compare. Returns the
  // line-compare interrupt pulse.
  function automatic logic bump_line();
    tstate.line = (tstate.line == lmlt_pkg::LINE_LAST) ? 8'd0 : tstate.line + 8'd1;
    n_lines++;
    if (tstate.line == regs.ly_compare) begin
      tstate.match = 1'b1;
      return regs.lyc_irq_enable;
    end
    tstate.match = 1'b0;
    return 1'b0;
  endfunction

  // One dot tick: updates tstate and returns the result item it causes.
  function automatic lmlt_pkg::result_t step_timing(input logic on);
    lmlt_pkg::result_t r;
    logic              vb, sw, spr, rend, lyc_p;
    vb = 1'b0; sw = 1'b0; spr = 1'b0; rend = 1'b0; lyc_p = 1'b0;
    if (!on) begin
      // display off: timing held cleared, coincidence kept, one blank swap
      tstate.dot  = '0;
      tstate.line = '0;
      tstate.win  = '0;
      tstate.mode = lmlt_pkg::MODE_HBLANK;
      if (!tstate.blank_done) begin
        sw = 1'b1;
        tstate.blank_done = 1'b1;
        n_blank++;
      end
    end else begin
      tstate.dot = tstate.dot + 9'd1;
      tstate.blank_done = 1'b0;
      case (tstate.mode)
        lmlt_pkg::MODE_HBLANK: begin
          if (tstate.dot >= lmlt_pkg::DOTS_HBLANK) begin
            tstate.dot = '0;
            lyc_p = bump_line();
            if (tstate.line == lmlt_pkg::LINES_VISIBLE) begin
              tstate.win  = '0;
              tstate.mode = lmlt_pkg::MODE_VBLANK;
              sw = 1'b1;
              vb = 1'b1;
            end else begin
              tstate.mode = lmlt_pkg::MODE_OAM;
              if (regs.window_enable && tstate.line > regs.window_y &&
                  regs.win_left <= lmlt_pkg::WX_LIMIT)
                tstate.win = tstate.win + 8'd1;
            end
          end
        end
        lmlt_pkg::MODE_VBLANK: begin
          if (tstate.dot >= lmlt_pkg::DOTS_LINE) begin
            tstate.dot = '0;
            lyc_p = bump_line();
            // last line is compared, then wraps within the same tick
            if (tstate.line >= lmlt_pkg::LINE_LAST) begin
              tstate.line = '0;
              tstate.mode = lmlt_pkg::MODE_OAM;
            end
          end
        end
        lmlt_pkg::MODE_OAM: begin
          if (tstate.dot >= lmlt_pkg::DOTS_OAM) begin
            tstate.dot  = '0;
            tstate.mode = lmlt_pkg::MODE_DRAW;
            spr = 1'b1;
          end
        end
        default: begin
          if (tstate.dot >= lmlt_pkg::DOTS_DRAW) begin
            tstate.dot  = '0;
            tstate.mode = lmlt_pkg::MODE_HBLANK;
            rend = 1'b1;
          end
        end
      endcase
    end
    n_lyc += lyc_p;
    r.mode              = tstate.mode;
    r.line              = tstate.line;
    r.window_line       = tstate.win;
    r.coincidence       = tstate.match;
    r.vblank_irq        = vb;
    r.lyc_irq           = lyc_p;
    r.frame_swap        = sw;
    r.sprite_eval_start = spr;
    r.line_render_start = rend;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: take-over at the rising edge, drive at the falling edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      timing_q.insert(timing_q.size(), step_timing(in_ch.lcd_on));
      n_ticks++;
      in_fire = 1'b1;
    end
  end

  // Driver: the slot is free when nothing is shown or the shown item was
  // just taken; then present the next tick, or idle about 30% of the time.
  always @(negedge clk) begin
    if (!in_ch.valid || in_fire) begin
      in_fire = 1'b0;
      if (tick_q.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
        in_ch.valid  <= 1'b1;
        in_ch.lcd_on <= tick_q.pop_front();
      end else begin
        in_ch.valid  <= 1'b0;
        in_ch.lcd_on <= $urandom_range(0, 1);  // junk while idle
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random back-pressure, in-order field compare
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin : result_check
    lmlt_pkg::result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.mode              = out_ch.mode;
      got.line              = out_ch.line;
      got.window_line       = out_ch.window_line;
      got.coincidence       = out_ch.coincidence;
      got.vblank_irq        = out_ch.vblank_irq;
      got.lyc_irq           = out_ch.lyc_irq;
      got.frame_swap        = out_ch.frame_swap;
      got.sprite_eval_start = out_ch.sprite_eval_start;
      got.line_render_start = out_ch.line_render_start;
      if (timing_q.size() == 0) begin
        report_mismatch("result with nothing expected", int'(got), 0);
      end else begin
        want = timing_q.pop_front();
        if (got.mode !== want.mode)
          report_mismatch("mode", got.mode, want.mode);
        if (got.line !== want.line)
          report_mismatch("line", got.line, want.line);
        if (got.window_line !== want.window_line)
          report_mismatch("window_line", got.window_line, want.window_line);
        if (got.coincidence !== want.coincidence)
          report_mismatch("coincidence", got.coincidence, want.coincidence);
        if (got.vblank_irq !== want.vblank_irq)
          report_mismatch("vblank_irq", got.vblank_irq, want.vblank_irq);
        if (got.lyc_irq !== want.lyc_irq)
          report_mismatch("lyc_irq", got.lyc_irq, want.lyc_irq);
        if (got.frame_swap !== want.frame_swap)
          report_mismatch("frame_swap", got.frame_swap, want.frame_swap);
        if (got.sprite_eval_start !== want.sprite_eval_start)
          report_mismatch("sprite_eval_start", got.sprite_eval_start,
                          want.sprite_eval_start);
        if (got.line_render_start !== want.line_render_start)
          report_mismatch("line_render_start", got.line_render_start,
                          want.line_render_start);
      end
      n_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any handshake or register write counts as progress
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no handshake for %0d cycles, %0d results pending",
               stall_cnt, timing_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Register writes and stimulus helpers
  // --------------------------------------------------------------------------
  // One register write; the bench copy follows at once since nothing is in flight.
  task automatic write_reg(input logic [lmlt_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lmlt_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      lmlt_pkg::REG_WINDOW_ENABLE:  regs.window_enable  = data[0];
      lmlt_pkg::REG_LY_COMPARE:     regs.ly_compare     = data;
      lmlt_pkg::REG_LYC_IRQ_ENABLE: regs.lyc_irq_enable = data[0];
      lmlt_pkg::REG_WINDOW_Y:       regs.window_y       = data;
      lmlt_pkg::REG_WIN_LEFT:       regs.win_left       = data;
      default: ;          // unmapped index, ignored by the block
    endcase
  endtask

  // Full register setting. One-bit registers get random upper data bits,
  // and now and then an unmapped index is written with junk.
  task automatic apply_setting(input bit we, input logic [7:0] lyc, input bit lie,
                               input logic [7:0] wy, input logic [7:0] wx);
    write_reg(lmlt_pkg::REG_WINDOW_ENABLE,  {7'($urandom), we});
    write_reg(lmlt_pkg::REG_LY_COMPARE,     lyc);
    write_reg(lmlt_pkg::REG_LYC_IRQ_ENABLE, {7'($urandom), lie});
    write_reg(lmlt_pkg::REG_WINDOW_Y,       wy);
    write_reg(lmlt_pkg::REG_WIN_LEFT,       wx);
    if ($urandom_range(0, 1))
      write_reg(lmlt_pkg::CFG_INDEX_W'($urandom_range(REG_COUNT, REG_INDEX_MAX)),
                8'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic queue_run(input bit on, input int unsigned n);
    repeat (n) tick_q.insert(tick_q.size(), on);
  endtask

  // Short runs broken up by display-off bursts.
  task automatic queue_bursts(input int unsigned segs, input int unsigned max_on);
    repeat (segs) begin
      queue_run(1'b0, $urandom_range(1, 3));
      queue_run(1'b1, $urandom_range(1, max_on));
    end
  endtask

  // Wait until every tick is sent and every result checked, then let the
  // result and skid registers settle before the configuration is touched.
  task automatic drain();
    @(negedge clk);
    while (tick_q.size() != 0 || in_ch.valid || timing_q.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.lcd_on = 1'b0;
    out_ch.ready = 1'b0;
    in_fire      = 1'b0;
    cycle_cnt    = 0;
    stall_cnt    = 0;
    n_err = 0; n_ticks = 0; n_checked = 0; n_settings = 0;
    n_lines = 0; n_lyc = 0; n_blank = 0;

    // after-reset state of the predictor and the register copy
    tstate.mode       = lmlt_pkg::MODE_OAM;
    tstate.dot        = '0;
    tstate.line       = '0;
    tstate.win        = '0;
    tstate.match      = 1'b0;
    tstate.blank_done = 1'b0;
    regs              = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ticks straight from reset with default registers. First off
    // tick gives the blank swap, a second one must not; an on tick re-arms it.
    queue_run(1'b1, 2);
    queue_run(1'b0, 2);
    queue_run(1'b1, 3);
    queue_run(1'b0, 1);
    queue_run(1'b1, 1);
    queue_run(1'b0, 3);
    queue_run(1'b1, 4);
    drain();

    // One line step out of HBLANK, then OAM scan and drawing of line 1: compare hit
    // on line 1, window counting with the left position right at the limit.
    apply_setting(1'b1, 8'd1, 1'b1, 8'd0, lmlt_pkg::WX_LIMIT);
    queue_run(1'b1, 520);
    drain();

    // restart from display-off, compare on line 2, left position just past
    // the limit so the window counter stays put
    apply_setting(1'b1, 8'd2, 1'b1, 8'd1, lmlt_pkg::WX_LIMIT + 8'd1);
    queue_run(1'b0, 1);
    queue_run(1'b1, 700);
    drain();

    // window disabled, compare never matches, interrupts masked
    apply_setting(1'b0, 8'hff, 1'b0, 8'($urandom_range(0, 143)), 8'd0);
    queue_bursts(4, 40);
    drain();

    // noise: lcd_on toggling at random under a random setting
    apply_setting($urandom_range(0, 1), 8'($urandom_range(0, 2)), $urandom_range(0, 1),
                  8'($urandom_range(0, 1)), 8'($urandom_range(160, 170)));
    repeat (150) tick_q.insert(tick_q.size(), 1'($urandom_range(0, 1)));
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (timing_q.size() != 0)
      report_mismatch("results never delivered", 0, timing_q.size());

    $display("Sent %0d dot ticks over %0d register settings; %0d results compared.",
             n_ticks, n_settings, n_checked);
    $display("Predicted %0d line steps, %0d compare irqs and %0d blank swaps.",
             n_lines, n_lyc, n_blank);
    if (n_err == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
